/* hw/rtl/i2r_pkg.sv */
package i2r_pkg;

	// Widths of the payload fields.
	localparam int VALUE_W = 12;
	localparam int CHAR_W  = 7;
	localparam int STEP_W  = 4;
	localparam int CNT_W   = 4;

	// A numeral is cut after this many letters.
	localparam int MAX_OUT = 15;

	// Number of entries in the greedy step table.
	localparam int N_STEPS = 13;

	// ASCII codes of the numeral letters.
	localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
	localparam logic [CHAR_W-1:0] CH_M    = 7'h4D;
	localparam logic [CHAR_W-1:0] CH_D    = 7'h44;
	localparam logic [CHAR_W-1:0] CH_C    = 7'h43;
	localparam logic [CHAR_W-1:0] CH_L    = 7'h4C;
	localparam logic [CHAR_W-1:0] CH_X    = 7'h58;
	localparam logic [CHAR_W-1:0] CH_V    = 7'h56;
	localparam logic [CHAR_W-1:0] CH_I    = 7'h49;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic last;
	} dp_stat_t;

	// Weight of each greedy step, largest first.
	function automatic logic [VALUE_W-1:0] step_val(input logic [STEP_W-1:0] idx);
		logic [VALUE_W-1:0] v;
		case (idx)
			4'd0:    v = 12'd1000;
			4'd1:    v = 12'd900;
			4'd2:    v = 12'd500;
			4'd3:    v = 12'd400;
			4'd4:    v = 12'd100;
			4'd5:    v = 12'd90;
			4'd6:    v = 12'd50;
			4'd7:    v = 12'd40;
			4'd8:    v = 12'd10;
			4'd9:    v = 12'd9;
			4'd10:   v = 12'd5;
			4'd11:   v = 12'd4;
			default: v = 12'd1;
		endcase
		return v;
	endfunction

	// First letter emitted for each step.
	function automatic logic [CHAR_W-1:0] step_first(input logic [STEP_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			4'd0:    c = CH_M;
			4'd1:    c = CH_C;
			4'd2:    c = CH_D;
			4'd3:    c = CH_C;
			4'd4:    c = CH_C;
			4'd5:    c = CH_X;
			4'd6:    c = CH_L;
			4'd7:    c = CH_X;
			4'd8:    c = CH_X;
			4'd9:    c = CH_I;
			4'd10:   c = CH_V;
			4'd11:   c = CH_I;
			default: c = CH_I;
		endcase
		return c;
	endfunction

	// Second letter of a subtractive pair, or none for a single letter.
	function automatic logic [CHAR_W-1:0] step_second(input logic [STEP_W-1:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			4'd1:    c = CH_M;
			4'd3:    c = CH_D;
			4'd5:    c = CH_C;
			4'd7:    c = CH_L;
			4'd9:    c = CH_X;
			4'd11:   c = CH_V;
			default: c = CH_NONE;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/i2r_ctrl.sv */
module i2r_ctrl
	import i2r_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.out_free) begin
					cmd.step = 1'b1;
					if (stat.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/i2r_dpath.sv */
module i2r_dpath
	import i2r_pkg::*;
#(
	parameter int MAX_THOUSANDS = 3
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [VALUE_W-1:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHAR_W-1:0]  out_char,
	output logic               out_last,
	output logic               out_error
);

	localparam int LIMIT = MAX_THOUSANDS * 1000 + 999;
	localparam logic [VALUE_W:0] LIMIT_W = LIMIT[VALUE_W:0];

	logic [VALUE_W-1:0] rest_q;
	logic               err_q;
	logic               pend_q;
	logic [CHAR_W-1:0]  sec_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               error_q;

	logic [STEP_W-1:0]  sel;
	logic [VALUE_W-1:0] rest_sub;
	logic [CHAR_W-1:0]  sec_w;
	logic [CHAR_W-1:0]  char_w;
	logic               last_w;
	logic               cut;
	logic               bad;

	// The value is rejected when zero or above the thousands limit.
	assign bad = (value == '0) || ({1'b0, value} > LIMIT_W);

	// Largest step weight that still fits in the remainder.
	always_comb begin
		sel = STEP_W'(N_STEPS - 1);
		for (int i = N_STEPS - 1; i >= 0; i--) begin
			if (rest_q >= step_val(STEP_W'(i))) begin
				sel = STEP_W'(i);
			end
		end
	end

	assign rest_sub = rest_q - step_val(sel);
	assign sec_w    = step_second(sel);
	assign cut      = (cnt_q == CNT_W'(MAX_OUT - 1));

	// Letter and end mark for the next word.
	always_comb begin
		if (err_q) begin
			char_w = CH_NONE;
			last_w = 1'b1;
		end else if (pend_q) begin
			char_w = sec_q;
			last_w = (rest_q == '0) || cut;
		end else begin
			char_w = step_first(sel);
			last_w = ((sec_w == CH_NONE) && (rest_sub == '0)) || cut;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.last     = last_w;

	// Conversion registers: remainder, error flag, pending second letter, letter count.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
			err_q  <= bad;
			pend_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.step && !err_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				rest_q <= rest_sub;
				sec_q  <= sec_w;
				pend_q <= (sec_w != CH_NONE) && !cut;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			char_q  <= char_w;
			last_q  <= last_w;
			error_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;
	assign out_error = error_q;

endmodule

/* hw/rtl/integer_to_roman_numeral_top.sv */
// Integer to Roman numeral converter.
//
// The slave channel takes one 12-bit unsigned value per word. The master
// channel returns its Roman numeral one ASCII letter per word, with tlast
// on the final letter. A zero, or a value above MAX_THOUSANDS*1000+999,
// returns a single word with tuser (error) set, tdata zero and tlast set.
//
// The value is first loaded into the conversion registers, and its first
// letter enters the output register once that register is free. The
// rate is set by the conversion loop, which emits one letter per cycle
// while the receiver keeps up, subtracting a step weight for each single
// letter or pair. A numeral has at most 15 letters.
//
// A new value is taken once the last letter of the previous one has been
// loaded into the output register, even while that letter still waits.
// When the receiver stalls, the output register holds its word and the
// conversion waits. Reset empties the output register and returns to idle.
module integer_to_roman_numeral_top
	import i2r_pkg::*;
#(
	parameter int MAX_THOUSANDS = 3
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [11:0] value, [15:12] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] out_char, [7] zero
	output logic        m_tlast,
	output logic        m_tuser   // [0] error
);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [CHAR_W-1:0] out_char;

	i2r_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	i2r_dpath #(
		.MAX_THOUSANDS (MAX_THOUSANDS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     (s_tdata[VALUE_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast),
		.out_error (m_tuser)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

/* hw/rtl/i2r_chk.sv */
module i2r_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// An error word stands alone and carries no letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
		else $error("error word without tlast or with a letter");

	// A good word always carries a letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[6:0] != 7'h00) && !m_tdata[7])
		else $error("numeral word without a letter");

	// Once a value is taken, the next one waits for its conversion.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("value taken while a conversion is running");

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled output word changed");

endmodule

bind integer_to_roman_numeral_top i2r_chk u_chk (.*);

/* dv/integer_to_roman_numeral_top_test.sv */
`timescale 1ns / 100ps

module integer_to_roman_numeral_top_test;
	import i2r_pkg::*;

	localparam int MAX_K        = 3;
	localparam int LARGEST      = MAX_K * 1000 + 999;
	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// One expected output word: a numeral letter with its flags.
	typedef struct packed {
		logic [CHAR_W-1:0] letter;
		logic              last;
		logic              err;
	} letter_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [11:0] value, [15:12] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // [6:0] out_char, [7] zero
	logic        m_tlast;
	logic        m_tuser;       // [0] error

	logic [VALUE_W-1:0] stim_values[$];
	letter_word_t       pending_letters[$];
	int                 sender_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 mismatches = 0;
	int                 words_seen = 0;
	int                 cycles = 0;

	integer_to_roman_numeral_top #(
		.MAX_THOUSANDS(MAX_K)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Append the letters of one decimal digit, given its unit, five and ten letters.
	function automatic void add_digit(inout logic [CHAR_W-1:0] seq[$], input int digit,
			input logic [CHAR_W-1:0] unit, input logic [CHAR_W-1:0] five,
			input logic [CHAR_W-1:0] ten);
		int n;
		if (digit == 9) begin
			seq.push_back(unit);
			seq.push_back(ten);
		end else if (digit == 4) begin
			seq.push_back(unit);
			seq.push_back(five);
		end else begin
			if (digit >= 5)
				seq.push_back(five);
			for (n = 0; n < digit % 5; n++)
				seq.push_back(unit);
		end
	endfunction

	// Work out the numeral of one value and queue its letters as expected words.
	function automatic void queue_numeral(input logic [VALUE_W-1:0] value);
		logic [CHAR_W-1:0] seq[$];
		letter_word_t      w;
		int                v;
		int                n;
		v = int'(value);
		if (v == 0 || v > LARGEST) begin
			w.letter = CH_NONE;
			w.last   = 1'b1;
			w.err    = 1'b1;
			pending_letters.push_back(w);
			return;
		end
		for (n = 0; n < v / 1000; n++)
			seq.push_back(CH_M);
		add_digit(seq, (v / 100) % 10, CH_C, CH_D, CH_M);
		add_digit(seq, (v / 10) % 10, CH_X, CH_L, CH_C);
		add_digit(seq, v % 10, CH_I, CH_V, CH_X);
		// A numeral longer than the output limit is cut short.
		while (seq.size() > MAX_OUT)
			void'(seq.pop_back());
		for (n = 0; n < seq.size(); n++) begin
			w.letter = seq[n];
			w.last   = (n == seq.size() - 1);
			w.err    = 1'b0;
			pending_letters.push_back(w);
		end
	endfunction

	// Random value, weighted toward long numerals with some zeros and overflows.
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		else if (r < 13)
			return VALUE_W'($urandom_range(4095, LARGEST + 1));
		else if (r < 30)
			return VALUE_W'($urandom_range(LARGEST, 3000));
		else
			return VALUE_W'($urandom_range(LARGEST, 1));
	endfunction

	// Driver: presents queued values and predicts the letters of each accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				queue_numeral(s_tdata[VALUE_W-1:0]);
			if (stim_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {4'h0, stim_values.pop_front()};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks every accepted letter against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		letter_word_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_letters.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected word %0d: tdata %h tlast %b tuser %b",
							words_seen, m_tdata, m_tlast, m_tuser);
				end else begin
					w = pending_letters.pop_front();
					if (m_tdata !== {1'b0, w.letter} || m_tlast !== w.last ||
							m_tuser !== w.err) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("word %0d: expected tdata %h tlast %b tuser %b, got %h %b %b",
								words_seen, {1'b0, w.letter}, w.last, w.err,
								m_tdata, m_tlast, m_tuser);
					end
				end
				words_seen++;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("** integer_to_roman_numeral_top: FAILED **");
			$finish;
		end
	end

	// Queue random values under one idling setting and wait until all letters are back.
	task automatic run_phase(input int n_values, input int idle_pct, input int stall_pct);
		int n;
		@(negedge clk);
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		for (n = 0; n < n_values; n++)
			stim_values.push_back(pick_value());
		while (stim_values.size() > 0 || s_tvalid || pending_letters.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed values: field extremes, every subtractive pair, the four-hundreds,
		// the longest numeral, the top of the range and just beyond it.
		stim_values = '{12'd0, 12'd1, 12'd4, 12'd9, 12'd14, 12'd40, 12'd49, 12'd90,
			12'd99, 12'd400, 12'd444, 12'd499, 12'd500, 12'd900, 12'd1000, 12'd1994,
			12'd2048, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2730, 12'd1365,
			12'd3141};

		run_phase(40, 0, 0);
		run_phase(40, 88, 0);
		run_phase(40, 0, 88);
		run_phase(30, 14, 14);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_letters.size() > 0) begin
			mismatches += pending_letters.size();
			$display("%0d expected words never arrived", pending_letters.size());
		end
		if (mismatches == 0)
			$display("** integer_to_roman_numeral_top: PASSED **");
		else
			$display("** integer_to_roman_numeral_top: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/i2r_pkg.sv
hw/rtl/i2r_ctrl.sv
hw/rtl/i2r_dpath.sv
hw/rtl/integer_to_roman_numeral_top.sv
hw/rtl/i2r_chk.sv
dv/integer_to_roman_numeral_top_test.sv
